/* rtl/cau_pkg.sv */
// shared types and constants for the complex arithmetic unit
// no dependencies
package cau_pkg;

    localparam int DEF_PART_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 8;
    localparam int ACTION_W       = 4;
    localparam int FLAGS_W        = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD       = 4'd0,
        ACT_SUB       = 4'd1,
        ACT_MUL       = 4'd2,
        ACT_DIV       = 4'd3,
        ACT_ADD_REAL  = 4'd4,
        ACT_SUB_REAL  = 4'd5,
        ACT_MUL_REAL  = 4'd6,
        ACT_DIV_REAL  = 4'd7,
        ACT_NEGATE    = 4'd8,
        ACT_MAGNITUDE = 4'd9,
        ACT_EQUAL     = 4'd10
    } action_t;

    typedef enum logic [1:0] {
        LK_DIRECT,
        LK_DIV,
        LK_SQRT
    } lane_kind_t;

    typedef struct packed {
        logic       valid;
        lane_kind_t kind_re;
        lane_kind_t kind_im;
        logic       neg_re;
        logic       neg_im;
        logic       eq;
        logic       dz;
    } side_t;

endpackage

/* rtl/cau_prep.sv */
// front end: operand products, then per-lane sign and magnitude setup
// depends on cau_pkg
module cau_prep import cau_pkg::*; #(
    parameter int PART_WIDTH = DEF_PART_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [ACTION_W-1:0]               action,
    input  logic signed [PART_WIDTH-1:0]      a_re,
    input  logic signed [PART_WIDTH-1:0]      a_im,
    input  logic signed [PART_WIDTH-1:0]      b_re,
    input  logic signed [PART_WIDTH-1:0]      b_im,
    output side_t                             side_o,
    output logic [2*PART_WIDTH+FRAC_BITS-1:0] rem_re_o,
    output logic [2*PART_WIDTH+FRAC_BITS-1:0] rem_im_o,
    output logic [2*PART_WIDTH-1:0]           den_o,
    output logic [2*PART_WIDTH-1:0]           sq_v_o
);

    localparam int W  = PART_WIDTH;
    localparam int DW = 2 * PART_WIDTH;
    localparam int SW = 2 * PART_WIDTH + 1;
    localparam int NW = 2 * PART_WIDTH + FRAC_BITS;

    logic                 a_valid_reg;
    action_t              act_reg;
    logic signed [W-1:0]  ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [DW-1:0] m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    logic signed [W-1:0]  x_op, y_op;

    side_t                side_next, side_reg;
    logic signed [SW-1:0] s_re, s_im;
    logic [DW-1:0]        mag_re, mag_im, den_next, sq_v_next;
    logic                 shift_mag, real_div;
    logic [NW-1:0]        rem_re_reg, rem_im_reg;
    logic [DW-1:0]        den_reg, sq_v_reg;

    // magnitude squares reuse the first two multipliers
    assign x_op = (action == ACT_MAGNITUDE) ? a_re : b_re;
    assign y_op = (action == ACT_MAGNITUDE) ? a_im : b_im;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
        if (en) begin
            act_reg <= action_t'(action);
            ar_reg  <= a_re;
            ai_reg  <= a_im;
            br_reg  <= b_re;
            bi_reg  <= b_im;
            m1_reg  <= DW'(a_re) * DW'(x_op);
            m2_reg  <= DW'(a_im) * DW'(y_op);
            m3_reg  <= DW'(a_re) * DW'(b_im);
            m4_reg  <= DW'(a_im) * DW'(b_re);
            m5_reg  <= DW'(b_re) * DW'(b_re);
            m6_reg  <= DW'(b_im) * DW'(b_im);
        end
    end

    always_comb begin
        side_next         = '0;
        side_next.valid   = a_valid_reg;
        side_next.kind_re = LK_DIRECT;
        side_next.kind_im = LK_DIRECT;
        s_re      = '0;
        s_im      = '0;
        den_next  = '0;
        sq_v_next = '0;
        shift_mag = 1'b0;
        real_div  = 1'b0;
        unique case (act_reg)
            ACT_ADD: begin
                s_re = SW'(ar_reg) + SW'(br_reg);
                s_im = SW'(ai_reg) + SW'(bi_reg);
            end
            ACT_SUB: begin
                s_re = SW'(ar_reg) - SW'(br_reg);
                s_im = SW'(ai_reg) - SW'(bi_reg);
            end
            ACT_MUL: begin
                s_re = SW'(m1_reg) - SW'(m2_reg);
                s_im = SW'(m3_reg) + SW'(m4_reg);
                shift_mag = 1'b1;
            end
            ACT_DIV: begin
                if (br_reg == '0 && bi_reg == '0) begin
                    side_next.dz = 1'b1;
                    s_re = SW'(ar_reg);
                    s_im = SW'(ai_reg);
                end else begin
                    side_next.kind_re = LK_DIV;
                    side_next.kind_im = LK_DIV;
                    s_re = SW'(m1_reg) + SW'(m2_reg);
                    s_im = SW'(m4_reg) - SW'(m3_reg);
                    den_next = DW'(m5_reg) + DW'(m6_reg);
                end
            end
            ACT_ADD_REAL: begin
                s_re = SW'(ar_reg) + SW'(br_reg);
                s_im = SW'(ai_reg);
            end
            ACT_SUB_REAL: begin
                s_re = SW'(ar_reg) - SW'(br_reg);
                s_im = SW'(ai_reg);
            end
            ACT_MUL_REAL: begin
                s_re = SW'(m1_reg);
                s_im = SW'(m4_reg);
                shift_mag = 1'b1;
            end
            ACT_DIV_REAL: begin
                s_re = SW'(ar_reg);
                s_im = SW'(ai_reg);
                if (br_reg == '0) begin
                    side_next.dz = 1'b1;
                end else begin
                    side_next.kind_re = LK_DIV;
                    side_next.kind_im = LK_DIV;
                    real_div = 1'b1;
                    den_next = br_reg[W-1] ? DW'(-SW'(br_reg)) : DW'(SW'(br_reg));
                end
            end
            ACT_NEGATE: begin
                s_re = -SW'(ar_reg);
                s_im = -SW'(ai_reg);
            end
            ACT_MAGNITUDE: begin
                side_next.kind_re = LK_SQRT;
                sq_v_next = DW'(m1_reg) + DW'(m2_reg);
            end
            ACT_EQUAL: begin
                side_next.eq = (ar_reg == br_reg) && (ai_reg == bi_reg);
            end
            default: begin
            end
        endcase

        side_next.neg_re = s_re[SW-1];
        side_next.neg_im = s_im[SW-1];
        mag_re = s_re[SW-1] ? DW'(-s_re) : DW'(s_re);
        mag_im = s_im[SW-1] ? DW'(-s_im) : DW'(s_im);
        if (shift_mag) begin
            mag_re = mag_re >> FRAC_BITS;
            mag_im = mag_im >> FRAC_BITS;
        end
        if (real_div) begin
            side_next.neg_re = (ar_reg[W-1] ^ br_reg[W-1]) && (ar_reg != '0);
            side_next.neg_im = (ai_reg[W-1] ^ br_reg[W-1]) && (ai_reg != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (en) begin
            side_reg <= side_next;
        end
        if (en) begin
            rem_re_reg <= NW'(mag_re) << FRAC_BITS;
            rem_im_reg <= NW'(mag_im) << FRAC_BITS;
            den_reg    <= den_next;
            sq_v_reg   <= sq_v_next;
        end
    end

    assign side_o   = side_reg;
    assign rem_re_o = rem_re_reg;
    assign rem_im_o = rem_im_reg;
    assign den_o    = den_reg;
    assign sq_v_o   = sq_v_reg;

endmodule

/* rtl/cau_cell.sv */
// one cell of the chain: a quotient bit for both lanes and a square root step
// depends on cau_pkg
module cau_cell import cau_pkg::*; #(
    parameter int PART_WIDTH = DEF_PART_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int IDX        = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  side_t                             side_i,
    input  logic [2*PART_WIDTH+FRAC_BITS-1:0] rem_re_i,
    input  logic [2*PART_WIDTH+FRAC_BITS-1:0] rem_im_i,
    input  logic [PART_WIDTH+1:0]             q_re_i,
    input  logic [PART_WIDTH+1:0]             q_im_i,
    input  logic [2*PART_WIDTH-1:0]           den_i,
    input  logic [2*PART_WIDTH-1:0]           sq_v_i,
    input  logic [2*PART_WIDTH-1:0]           sq_res_i,
    output side_t                             side_o,
    output logic [2*PART_WIDTH+FRAC_BITS-1:0] rem_re_o,
    output logic [2*PART_WIDTH+FRAC_BITS-1:0] rem_im_o,
    output logic [PART_WIDTH+1:0]             q_re_o,
    output logic [PART_WIDTH+1:0]             q_im_o,
    output logic [2*PART_WIDTH-1:0]           den_o,
    output logic [2*PART_WIDTH-1:0]           sq_v_o,
    output logic [2*PART_WIDTH-1:0]           sq_res_o
);

    localparam int DW    = 2 * PART_WIDTH;
    localparam int NW    = 2 * PART_WIDTH + FRAC_BITS;
    localparam int QW    = PART_WIDTH + 2;
    localparam int CW    = 3 * PART_WIDTH + 2;
    localparam int K     = PART_WIDTH + 1 - IDX;
    localparam bit SQ_ON = IDX < PART_WIDTH;
    localparam int SB    = (IDX < PART_WIDTH) ? 2 * (PART_WIDTH - 1 - IDX) : 0;
    localparam logic [DW-1:0] SQ_BIT = DW'(1) << SB;

    logic [CW-1:0] den_sh;
    logic          do_re, do_im;
    logic [NW-1:0] rem_re_next, rem_im_next;
    logic [DW:0]   sq_t;
    logic [DW-1:0] sq_v_next, sq_res_next;

    side_t         side_reg;
    logic [NW-1:0] rem_re_reg, rem_im_reg;
    logic [QW-1:0] q_re_reg, q_im_reg;
    logic [DW-1:0] den_reg, sq_v_reg, sq_res_reg;

    always_comb begin
        den_sh = CW'(den_i) << K;
        do_re  = (side_i.kind_re == LK_DIV) && (CW'(rem_re_i) >= den_sh);
        do_im  = (side_i.kind_im == LK_DIV) && (CW'(rem_im_i) >= den_sh);
        rem_re_next = do_re ? NW'(CW'(rem_re_i) - den_sh) : rem_re_i;
        rem_im_next = do_im ? NW'(CW'(rem_im_i) - den_sh) : rem_im_i;

        sq_t        = (DW+1)'(sq_res_i) + (DW+1)'(SQ_BIT);
        sq_v_next   = sq_v_i;
        sq_res_next = sq_res_i;
        if (SQ_ON && side_i.kind_re == LK_SQRT) begin
            if ((DW+1)'(sq_v_i) >= sq_t) begin
                sq_v_next   = DW'((DW+1)'(sq_v_i) - sq_t);
                sq_res_next = (sq_res_i >> 1) + SQ_BIT;
            end else begin
                sq_res_next = sq_res_i >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (en) begin
            side_reg <= side_i;
        end
        if (en) begin
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            q_re_reg   <= {q_re_i[QW-2:0], do_re};
            q_im_reg   <= {q_im_i[QW-2:0], do_im};
            den_reg    <= den_i;
            sq_v_reg   <= sq_v_next;
            sq_res_reg <= sq_res_next;
        end
    end

    assign side_o   = side_reg;
    assign rem_re_o = rem_re_reg;
    assign rem_im_o = rem_im_reg;
    assign q_re_o   = q_re_reg;
    assign q_im_o   = q_im_reg;
    assign den_o    = den_reg;
    assign sq_v_o   = sq_v_reg;
    assign sq_res_o = sq_res_reg;

endmodule

/* rtl/complex_arithmetic_unit.sv */
// complex arithmetic unit top level: front end, cell chain, saturation and output register
// depends on cau_pkg, cau_prep, cau_cell
//
// usage
//   input beats carry one operation: s_tuser holds the action code, s_tdata the
//   operands a_re, a_im, b_re, b_im (signed fixed point, PART_WIDTH bits each).
//   every input beat yields exactly one output beat, in order: m_tdata holds
//   res_re and res_im, m_tuser the flags equal, div_by_zero and saturated.
//   the path runs through two front-end stages, one cell per quotient bit
//   (PART_WIDTH + 2 cells, the square root steps share the first PART_WIDTH
//   of them) and the output register. throughput is one beat per cycle while
//   m_tready does not stall it; the chain of cells is fully pipelined.
//   when the receiver holds m_tready low with a beat waiting, the whole
//   pipeline stalls and s_tready drops in the same cycle; nothing is lost.
//   reset clears all valid bits; the data path needs no reset.
module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int PART_WIDTH = DEF_PART_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [4*PART_WIDTH-1:0] s_tdata,  // a_re, a_im, b_re, b_im
    input  logic [ACTION_W-1:0]     s_tuser,  // action
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [2*PART_WIDTH-1:0] m_tdata,  // res_re, res_im
    output logic [FLAGS_W-1:0]      m_tuser   // equal, div_by_zero, saturated
);

    localparam int W  = PART_WIDTH;
    localparam int DW = 2 * PART_WIDTH;
    localparam int NW = 2 * PART_WIDTH + FRAC_BITS;
    localparam int QW = PART_WIDTH + 2;
    localparam int L  = PART_WIDTH + 2;

    function automatic logic [W:0] clip_part(input logic neg, input logic [DW-1:0] mag);
        logic [DW-1:0] lim;
        logic          sat;
        logic [W-1:0]  v;
        lim = neg ? (DW'(1) << (W - 1)) : ((DW'(1) << (W - 1)) - DW'(1));
        sat = mag > lim;
        v   = sat ? W'(lim) : (neg ? W'(DW'(0) - mag) : W'(mag));
        return {sat, v};
    endfunction

    logic en;

    side_t         side_c   [L+1];
    logic [NW-1:0] rem_re_c [L+1];
    logic [NW-1:0] rem_im_c [L+1];
    logic [QW-1:0] q_re_c   [L+1];
    logic [QW-1:0] q_im_c   [L+1];
    logic [DW-1:0] den_c    [L+1];
    logic [DW-1:0] sq_v_c   [L+1];
    logic [DW-1:0] sq_res_c [L+1];

    side_t         tail;
    logic [DW-1:0] mag_re, mag_im;
    logic [W:0]    clip_re, clip_im;

    logic               m_tvalid_reg;
    logic [DW-1:0]      m_tdata_reg;
    logic [FLAGS_W-1:0] m_tuser_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    cau_prep #(
        .PART_WIDTH (PART_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .action   (s_tuser),
        .a_re     (s_tdata[W-1:0]),
        .a_im     (s_tdata[2*W-1:W]),
        .b_re     (s_tdata[3*W-1:2*W]),
        .b_im     (s_tdata[4*W-1:3*W]),
        .side_o   (side_c[0]),
        .rem_re_o (rem_re_c[0]),
        .rem_im_o (rem_im_c[0]),
        .den_o    (den_c[0]),
        .sq_v_o   (sq_v_c[0])
    );

    assign q_re_c[0]   = '0;
    assign q_im_c[0]   = '0;
    assign sq_res_c[0] = '0;

    for (genvar i = 0; i < L; i++) begin : g_chain
        cau_cell #(
            .PART_WIDTH (PART_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .IDX        (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .side_i   (side_c[i]),
            .rem_re_i (rem_re_c[i]),
            .rem_im_i (rem_im_c[i]),
            .q_re_i   (q_re_c[i]),
            .q_im_i   (q_im_c[i]),
            .den_i    (den_c[i]),
            .sq_v_i   (sq_v_c[i]),
            .sq_res_i (sq_res_c[i]),
            .side_o   (side_c[i+1]),
            .rem_re_o (rem_re_c[i+1]),
            .rem_im_o (rem_im_c[i+1]),
            .q_re_o   (q_re_c[i+1]),
            .q_im_o   (q_im_c[i+1]),
            .den_o    (den_c[i+1]),
            .sq_v_o   (sq_v_c[i+1]),
            .sq_res_o (sq_res_c[i+1])
        );
    end

    assign tail = side_c[L];

    always_comb begin
        case (tail.kind_re)
            LK_DIV:  mag_re = DW'(q_re_c[L]);
            LK_SQRT: mag_re = sq_res_c[L];
            default: mag_re = DW'(rem_re_c[L] >> FRAC_BITS);
        endcase
        case (tail.kind_im)
            LK_DIV:  mag_im = DW'(q_im_c[L]);
            default: mag_im = DW'(rem_im_c[L] >> FRAC_BITS);
        endcase
        clip_re = clip_part(tail.neg_re, mag_re);
        clip_im = clip_part(tail.neg_im, mag_im);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= tail.valid;
        end
        if (en) begin
            m_tdata_reg <= {clip_im[W-1:0], clip_re[W-1:0]};
            m_tuser_reg <= {clip_re[W] | clip_im[W], tail.dz, tail.eq};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a zero-divisor beat passes a through and never clips
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[2])
        else $error("div_by_zero beat flagged as saturated");

    // compare beats carry a zero result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("equal beat with nonzero result or divide flag");

    // square root of a 2W-bit value fits in W bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        tail.valid && tail.kind_re == LK_SQRT |-> sq_res_c[L][DW-1:W] == '0)
        else $error("square root result out of range");

    // stall freezes the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(m_tdata_reg) && $stable(m_tuser_reg) && m_tvalid_reg)
        else $error("output register moved during stall");

endmodule

/* sim/complex_arithmetic_unit_tb.sv */
// testbench for the complex arithmetic unit: random and directed operations checked
// against a behavioral predictor of the fixed-point results and flags
// depends on cau_pkg and complex_arithmetic_unit
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    localparam int PW = DEF_PART_WIDTH;
    localparam int FB = DEF_FRAC_BITS;
    localparam longint PMAX = (64'sd1 <<< (PW - 1)) - 1;
    localparam longint PMIN = -(64'sd1 <<< (PW - 1));
    localparam longint QLIM = 64'sd1 <<< 33;
    localparam int N_RANDOM = 450;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [PW-1:0]       a_re;
        logic [PW-1:0]       a_im;
        logic [PW-1:0]       b_re;
        logic [PW-1:0]       b_im;
    } op_t;

    typedef struct packed {
        logic [PW-1:0] res_re;
        logic [PW-1:0] res_im;
        logic          equal;
        logic          div_by_zero;
        logic          saturated;
    } res_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [4*PW-1:0]     s_tdata = '0;
    logic [ACTION_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [2*PW-1:0]     m_tdata;
    logic [FLAGS_W-1:0]  m_tuser;

    op_t    pending_ops[$];
    res_t   expected_results[$];
    int     errors = 0;
    int     n_checked = 0;
    int     burst_left = 0;
    int     gap_left = 0;
    int     cycles = 0;
    int     stall_phase = 0;
    bit     hold_off = 1'b0;
    bit     stim_done = 1'b0;
    bit     in_fire = 1'b0;

    complex_arithmetic_unit i_dut (.*);

    always #10 aclk = ~aclk;

    function automatic longint clip_part(longint v, inout bit sat);
        if (v > PMAX) begin
            sat = 1'b1;
            return PMAX;
        end
        if (v < PMIN) begin
            sat = 1'b1;
            return PMIN;
        end
        return v;
    endfunction

    // truncating fixed-point quotient magnitude, clamped like the hardware
    function automatic longint quot_mag(longint num, longint den);
        longint q;
        q = num / den;
        if (q > QLIM) return QLIM;
        q = (num * (64'sd1 <<< FB)) / den;
        return (q > QLIM) ? QLIM : q;
    endfunction

    function automatic longint signed_quot(longint num, longint den);
        longint m;
        m = quot_mag(num < 0 ? -num : num, den);
        return (num < 0) ? -m : m;
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        r = longint'($sqrt(real'(v)));
        while (r * r > v) r--;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function automatic res_t predict_result(op_t op);
        longint ar, ai, br, bi, rr, ri, den;
        bit     sat;
        res_t   r;
        ar = longint'(signed'(op.a_re));
        ai = longint'(signed'(op.a_im));
        br = longint'(signed'(op.b_re));
        bi = longint'(signed'(op.b_im));
        rr = 0;
        ri = 0;
        sat = 1'b0;
        r = '0;
        case (op.action)
            ACT_ADD: begin
                rr = clip_part(ar + br, sat);
                ri = clip_part(ai + bi, sat);
            end
            ACT_SUB: begin
                rr = clip_part(ar - br, sat);
                ri = clip_part(ai - bi, sat);
            end
            ACT_MUL: begin
                rr = clip_part((ar * br - ai * bi) / (64'sd1 <<< FB), sat);
                ri = clip_part((ar * bi + ai * br) / (64'sd1 <<< FB), sat);
            end
            ACT_DIV: begin
                if (br == 0 && bi == 0) begin
                    r.div_by_zero = 1'b1;
                    rr = ar;
                    ri = ai;
                end else begin
                    den = br * br + bi * bi;
                    rr = clip_part(signed_quot(ar * br + ai * bi, den), sat);
                    ri = clip_part(signed_quot(ai * br - ar * bi, den), sat);
                end
            end
            ACT_ADD_REAL: begin
                rr = clip_part(ar + br, sat);
                ri = ai;
            end
            ACT_SUB_REAL: begin
                rr = clip_part(ar - br, sat);
                ri = ai;
            end
            ACT_MUL_REAL: begin
                rr = clip_part((ar * br) / (64'sd1 <<< FB), sat);
                ri = clip_part((ai * br) / (64'sd1 <<< FB), sat);
            end
            ACT_DIV_REAL: begin
                if (br == 0) begin
                    r.div_by_zero = 1'b1;
                    rr = ar;
                    ri = ai;
                end else begin
                    den = (br < 0) ? -br : br;
                    rr = clip_part((br < 0) ? -signed_quot(ar, den) : signed_quot(ar, den), sat);
                    ri = clip_part((br < 0) ? -signed_quot(ai, den) : signed_quot(ai, den), sat);
                end
            end
            ACT_NEGATE: begin
                rr = clip_part(-ar, sat);
                ri = clip_part(-ai, sat);
            end
            ACT_MAGNITUDE: rr = clip_part(root_floor(ar * ar + ai * ai), sat);
            ACT_EQUAL: r.equal = (ar == br) && (ai == bi);
            default: ;
        endcase
        r.res_re = rr[PW-1:0];
        r.res_im = ri[PW-1:0];
        r.saturated = sat;
        return r;
    endfunction

    function automatic op_t make_op(int act, longint ar, longint ai, longint br, longint bi);
        op_t op;
        op.action = act[ACTION_W-1:0];
        op.a_re = ar[PW-1:0];
        op.a_im = ai[PW-1:0];
        op.b_re = br[PW-1:0];
        op.b_im = bi[PW-1:0];
        return op;
    endfunction

    // mostly small operands so products and quotients stay in range
    function automatic logic [PW-1:0] rand_part();
        case ($urandom_range(0, 5))
            0: return PW'($urandom());
            1: return $urandom_range(0, 3) == 0 ? PMIN[PW-1:0] : PMAX[PW-1:0];
            2: return '0;
            default: return PW'(longint'($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    // driver: bursts with random gaps, fed from the pending queue
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_fire)
                void'(pending_ops.pop_front());
            if (s_tvalid && !in_fire) begin
            end else if (pending_ops.size() != 0 && !hold_off
                         && (gap_left == 0 || burst_left > 0)) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                end
                burst_left--;
                if (burst_left == 0)
                    gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
                s_tvalid <= 1'b1;
                s_tuser <= pending_ops[0].action;
                s_tdata <= {pending_ops[0].b_im, pending_ops[0].b_re,
                            pending_ops[0].a_im, pending_ops[0].a_re};
            end else begin
                if (gap_left > 0) gap_left--;
                s_tvalid <= 1'b0;
            end
            stall_phase = (stall_phase + 1) % 97;
            m_tready <= (stall_phase < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    // predictor on input acceptance, checker on output acceptance
    always @(posedge aclk) begin
        res_t got, exp_r;
        cycles++;
        in_fire = aresetn && s_tvalid && s_tready;
        if (in_fire)
            expected_results.push_back(predict_result(
                make_op(s_tuser, longint'(signed'(s_tdata[PW-1:0])),
                        longint'(signed'(s_tdata[2*PW-1:PW])),
                        longint'(signed'(s_tdata[3*PW-1:2*PW])),
                        longint'(signed'(s_tdata[4*PW-1:3*PW])))));
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[PW-1:0], m_tdata[2*PW-1:PW], m_tuser[0], m_tuser[1], m_tuser[2]};
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, got);
            end else begin
                exp_r = expected_results.pop_front();
                n_checked++;
                if (got !== exp_r) begin
                    errors++;
                    $display("%0t: mismatch expected re=%h im=%h eq=%b dz=%b sat=%b",
                             $time, exp_r.res_re, exp_r.res_im, exp_r.equal,
                             exp_r.div_by_zero, exp_r.saturated);
                    $display("%0t:          actual   re=%h im=%h eq=%b dz=%b sat=%b",
                             $time, got.res_re, got.res_im, got.equal,
                             got.div_by_zero, got.saturated);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: extremes, every operation, zero divisors, negate of minimum
        for (int a = 0; a <= ACT_EQUAL; a++)
            pending_ops.push_back(make_op(a, PMAX, PMIN, PMAX, PMAX));
        pending_ops.push_back(make_op(ACT_DIV, 256, -512, 0, 0));
        pending_ops.push_back(make_op(ACT_DIV_REAL, PMIN, PMAX, 0, 77));
        pending_ops.push_back(make_op(ACT_NEGATE, PMIN, 0, 0, 0));
        pending_ops.push_back(make_op(ACT_MAGNITUDE, PMIN, PMIN, 0, 0));
        pending_ops.push_back(make_op(ACT_EQUAL, 300, -5, 300, -5));
        pending_ops.push_back(make_op(ACT_DIV, 1, 0, 1, 0));
        pending_ops.push_back(make_op(ACT_MUL, PMIN, PMIN, PMIN, PMIN));
        pending_ops.push_back(make_op(ACT_DIV_REAL, -300, 300, -1, 0));
        pending_ops.push_back(make_op(11, 5, 5, 5, 5));
        pending_ops.push_back(make_op(15, -1, -1, -1, -1));
        wait (pending_ops.size() == 0);
        // pause until the pipeline has drained
        hold_off = 1'b1;
        wait (expected_results.size() == 0);
        hold_off = 1'b0;
        for (int i = 0; i < N_RANDOM; i++) begin
            op_t op;
            op.action = ($urandom_range(0, 19) == 0) ? ACTION_W'($urandom_range(11, 15))
                                                     : ACTION_W'($urandom_range(0, 10));
            op.a_re = rand_part();
            op.a_im = rand_part();
            op.b_re = ($urandom_range(0, 9) == 0) ? '0 : rand_part();
            op.b_im = ($urandom_range(0, 9) == 0) ? '0 : rand_part();
            if (op.action == ACT_EQUAL && $urandom_range(0, 1)) begin
                op.b_re = op.a_re;
                op.b_im = $urandom_range(0, 1) ? op.a_im : rand_part();
            end
            pending_ops.push_back(op);
        end
        wait (pending_ops.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
        repeat (3 * (PW + 5)) @(posedge aclk);
        $display("checked %0d result beats over all eleven operations and unused codes",
                 n_checked);
        if (errors == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
